>>> rtl/bdf_pkg.sv
package bdf_pkg;

  localparam int unsigned PixW       = 8;
  localparam int unsigned CoordW     = 4;
  localparam int unsigned HalfW      = 3;
  localparam int unsigned WeightW    = 17;
  localparam int unsigned D2W        = 7;
  localparam int unsigned ProdW      = PixW + WeightW;
  localparam int unsigned NumW       = 32;
  localparam int unsigned DenW       = 24;
  localparam int unsigned DividendW  = NumW + 2;
  localparam int unsigned DivisorW   = DenW + 1;
  localparam int unsigned QuotW      = 9;
  localparam int unsigned CntW       = $clog2(QuotW);
  localparam int unsigned SpatialEntries = 99;
  localparam int unsigned RangeEntries   = 256;
  localparam logic [2:0]  HalfReset  = 3'd2;
  localparam logic [PixW-1:0] PixMax = 8'd255;

  localparam logic FuncLoad   = 1'b0;
  localparam logic FuncFilter = 1'b1;

  localparam logic [63:0] Q30One     = 64'd1 << 30;
  localparam logic [63:0] SpatialDen = 64'd32;
  localparam logic [63:0] RangeDen   = 64'd800;
  localparam logic [63:0] RoundHalf  = 64'd8192;

  typedef logic [WeightW-1:0] spatial_rom_t [SpatialEntries];
  typedef logic [WeightW-1:0] range_rom_t [RangeEntries];

  // exp(-r/den) in q2.30, alternating series with truncated terms
  function automatic logic [63:0] series_q30(logic [63:0] r, logic is_range);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = Q30One;
    term = Q30One;
    for (int k = 1; k <= 24; k++) begin
      term = term * r;
      term = is_range ? term / RangeDen : term / SpatialDen;
      term = term / 64'(k);
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // exp(-num/den) rounded to q1.16
  function automatic logic [WeightW-1:0] exp_q16(logic [63:0] num, logic is_range);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] v;
    logic [63:0] e1;
    q   = is_range ? num / RangeDen : num / SpatialDen;
    rem = num - q * (is_range ? RangeDen : SpatialDen);
    if (q > 64'd24) begin
      return '0;
    end
    v  = series_q30(rem, is_range);
    e1 = series_q30(is_range ? RangeDen : SpatialDen, is_range);
    for (int n = 0; n < 24; n++) begin
      if (64'(n) < q) begin
        v = (v * e1) >> 30;
      end
    end
    return WeightW'((v + RoundHalf) >> 14);
  endfunction

  function automatic spatial_rom_t build_spatial();
    spatial_rom_t t;
    for (int n = 0; n < SpatialEntries; n++) begin
      t[n] = exp_q16(64'(n), 1'b0);
    end
    return t;
  endfunction

  // indexed by the absolute difference, holds exp(-diff^2/800)
  function automatic range_rom_t build_range();
    range_rom_t t;
    for (int d = 0; d < RangeEntries; d++) begin
      t[d] = exp_q16(64'(d * d), 1'b1);
    end
    return t;
  endfunction

  localparam spatial_rom_t SpatialRom = build_spatial();
  localparam range_rom_t   RangeRom   = build_range();

endpackage

>>> rtl/bdf_if.sv
interface bdf_req_if import bdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [CoordW-1:0] row;
  logic [CoordW-1:0] col;
  logic [PixW-1:0]   pixel;

  modport source (output valid, func, row, col, pixel, input ready);
  modport sink (input valid, func, row, col, pixel, output ready);
endinterface

interface bdf_rsp_if import bdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PixW-1:0]   filtered;
  logic [CoordW-1:0] out_row;
  logic [CoordW-1:0] out_col;

  modport source (output valid, filtered, out_row, out_col, input ready);
  modport sink (input valid, filtered, out_row, out_col, output ready);
endinterface

>>> rtl/bilateral_depth_filter.sv
// channel  | dir | payload                       | transaction
// req_i    | in  | func, row, col, pixel         | valid && ready
// rsp_o    | out | filtered, out_row, out_col    | valid && ready
// cfg      | in  | cfg_wdata_i (half_window)     | cfg_we_i
// a load is written to image memory as it is accepted; a filter runs through accept,
// centre read, one window tap per cycle, drain, divider start, 9 divider steps and done
// wait, and finish; a centre outside the image goes from accept straight to finish
// reset clears control state and sets half_window to 2; image memory is not cleared
// a result waits in the output register while the next request is taken; a later
// result holds in finish until the register is free
module bilateral_depth_filter import bdf_pkg::*; #(
  parameter int unsigned IMAGE_ROWS = 16,
  parameter int unsigned IMAGE_COLS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [HalfW-1:0] cfg_wdata_i,
  bdf_req_if.sink          req_i,
  bdf_rsp_if.source        rsp_o
);

  localparam int unsigned Depth = IMAGE_ROWS * IMAGE_COLS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [6:0] {
    StIdle    = 7'b0000001,
    StCentre  = 7'b0000010,
    StTaps    = 7'b0000100,
    StDrain   = 7'b0001000,
    StDivGo   = 7'b0010000,
    StDivWait = 7'b0100000,
    StFinish  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [HalfW-1:0]  half_q;
  logic              in_acc;
  logic              in_ok;
  logic [AddrW-1:0]  in_addr;
  logic              mem_we;
  logic [AddrW-1:0]  mem_raddr;
  logic [PixW-1:0]   image_mem [Depth];
  logic [PixW-1:0]   rdata_q;

  logic [CoordW-1:0] row_q, col_q;
  logic              zero_q, zero_d;
  logic [PixW-1:0]   centre_q;
  logic signed [3:0] ti_q, ti_d, tj_q, tj_d;
  logic [1:0]        drain_q, drain_d;
  logic signed [3:0] h_s;
  logic signed [5:0] ny, nx;
  logic              tap_in;
  logic [AddrW-1:0]  tap_addr;
  logic signed [7:0] ti_e, tj_e, sqi, sqj;
  logic [D2W-1:0]    d2;

  logic               v1_q, v2_q, v3_q, v4_q;
  logic [D2W-1:0]     d2_1_q;
  logic [PixW-1:0]    diff;
  logic [WeightW-1:0] s2_q, r2_q, w3_q, w4_q;
  logic [PixW-1:0]    tap2_q, tap3_q;
  logic [2*WeightW-1:0] wprod;
  logic [ProdW-1:0]   p4_q;
  logic [NumW-1:0]    num_q;
  logic [DenW-1:0]    den_q;

  logic                 div_start;
  logic                 div_done;
  logic [QuotW-1:0]     quot;
  logic [DividendW-1:0] dividend;
  logic [DivisorW-1:0]  divisor;

  logic              out_valid_q;
  logic              out_load;
  logic [PixW-1:0]   filtered_q;
  logic [CoordW-1:0] orow_q, ocol_q;

  assign req_i.ready = (state_q == StIdle);
  assign in_acc      = req_i.valid && req_i.ready;
  assign in_ok       = (32'(req_i.row) < IMAGE_ROWS) && (32'(req_i.col) < IMAGE_COLS);
  assign in_addr     = AddrW'(32'(req_i.row) * IMAGE_COLS + 32'(req_i.col));
  assign mem_we      = in_acc && (req_i.func == FuncLoad) && in_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= HalfReset;
    end else if (cfg_we_i) begin
      half_q <= cfg_wdata_i;
    end
  end

  // window tap address
  assign h_s    = $signed({1'b0, half_q});
  assign ny     = $signed({2'b00, row_q}) + 6'(ti_q);
  assign nx     = $signed({2'b00, col_q}) + 6'(tj_q);
  assign tap_in = !ny[5] && !nx[5] && (32'(unsigned'(ny)) < IMAGE_ROWS) &&
                  (32'(unsigned'(nx)) < IMAGE_COLS);
  assign tap_addr = AddrW'(32'(unsigned'(ny)) * IMAGE_COLS + 32'(unsigned'(nx)));
  assign ti_e   = 8'(ti_q);
  assign tj_e   = 8'(tj_q);
  assign sqi    = ti_e * ti_e;
  assign sqj    = tj_e * tj_e;
  assign d2     = D2W'(unsigned'(sqi)) + D2W'(unsigned'(sqj));

  assign mem_raddr = (state_q == StIdle) ? in_addr : tap_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      image_mem[in_addr] <= req_i.pixel;
    end
    rdata_q <= image_mem[mem_raddr];
  end

  // control
  always_comb begin
    state_d = state_q;
    zero_d  = zero_q;
    ti_d    = ti_q;
    tj_d    = tj_q;
    drain_d = drain_q;
    unique case (state_q)
      StIdle: begin
        if (in_acc && (req_i.func == FuncFilter)) begin
          zero_d  = !in_ok;
          state_d = in_ok ? StCentre : StFinish;
        end
      end
      StCentre: begin
        ti_d    = -h_s;
        tj_d    = -h_s;
        state_d = StTaps;
      end
      StTaps: begin
        if (tj_q == h_s) begin
          tj_d = -h_s;
          ti_d = ti_q + 4'sd1;
          if (ti_q == h_s) begin
            drain_d = '0;
            state_d = StDrain;
          end
        end else begin
          tj_d = tj_q + 4'sd1;
        end
      end
      StDrain: begin
        drain_d = drain_q + 2'd1;
        if (drain_q == 2'd3) begin
          state_d = StDivGo;
        end
      end
      StDivGo: begin
        state_d = StDivWait;
      end
      StDivWait: begin
        if (div_done) begin
          state_d = StFinish;
        end
      end
      StFinish: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      zero_q  <= 1'b0;
      ti_q    <= '0;
      tj_q    <= '0;
      drain_q <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      zero_q  <= zero_d;
      ti_q    <= ti_d;
      tj_q    <= tj_d;
      drain_q <= drain_d;
      v1_q    <= (state_q == StTaps) && tap_in;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
    end
  end

  // tap pipeline: read, table lookup, weight, product, accumulate
  assign diff  = (rdata_q > centre_q) ? rdata_q - centre_q : centre_q - rdata_q;
  assign wprod = (2*WeightW)'(s2_q) * (2*WeightW)'(r2_q);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      row_q <= req_i.row;
      col_q <= req_i.col;
    end
    if (state_q == StCentre) begin
      centre_q <= rdata_q;
      num_q    <= '0;
      den_q    <= '0;
    end else if (v4_q) begin
      num_q <= num_q + NumW'(p4_q);
      den_q <= den_q + DenW'(w4_q);
    end
    d2_1_q <= d2;
    s2_q   <= SpatialRom[d2_1_q];
    r2_q   <= RangeRom[diff];
    tap2_q <= rdata_q;
    w3_q   <= wprod[WeightW+15:16];
    tap3_q <= tap2_q;
    p4_q   <= ProdW'(tap3_q) * ProdW'(w3_q);
    w4_q   <= w3_q;
  end

  // rounded quotient (2*num + den) / (2*den)
  assign div_start = (state_q == StDivGo);
  assign dividend  = DividendW'({num_q, 1'b0}) + DividendW'(den_q);
  assign divisor   = {den_q, 1'b0};

  bdf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // output register
  assign out_load = (state_q == StFinish) && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      if (zero_q) begin
        filtered_q <= '0;
      end else if (quot > QuotW'(PixMax)) begin
        filtered_q <= PixMax;
      end else begin
        filtered_q <= quot[PixW-1:0];
      end
      orow_q <= row_q;
      ocol_q <= col_q;
    end
  end

  assign rsp_o.valid    = out_valid_q;
  assign rsp_o.filtered = filtered_q;
  assign rsp_o.out_row  = orow_q;
  assign rsp_o.out_col  = ocol_q;

endmodule

>>> rtl/bdf_div.sv
module bdf_div import bdf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [QuotW-1:0]     quot_o
);

  localparam int unsigned ShW = DivisorW + QuotW - 1;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DividendW-1:0] rem_q, rem_d;
  logic [ShW-1:0]       dsh_q, dsh_d;
  logic [QuotW-1:0]     quot_q, quot_d;
  logic                 fits;

  assign fits = rem_q >= DividendW'(dsh_q);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(QuotW - 1);
      rem_d  = dividend_i;
      dsh_d  = {divisor_i, {(QuotW-1){1'b0}}};
      quot_d = '0;
    end else if (busy_q) begin
      // restoring step, one quotient bit per cycle
      if (fits) begin
        rem_d = rem_q - DividendW'(dsh_q);
      end
      quot_d = {quot_q[QuotW-2:0], fits};
      dsh_d  = dsh_q >> 1;
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
